// ===== rtl/knis_pkg.sv =====
// shared constants, codes and types for the k-nearest insertion selector
`default_nettype none

package knis_pkg;

    localparam int MAX_K      = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = 16;
    localparam int DIST_BITS  = 36;
    localparam int RANK_BITS  = 4;
    localparam int COUNT_BITS = 5;
    localparam int SEEN_BITS  = 17;
    localparam int OP_BITS    = 2;
    localparam int SQ_BITS    = 2 * COORD_BITS;

    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POINT  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

    localparam logic [COUNT_BITS-1:0] K_RESET = 5'd16;
    localparam logic [COUNT_BITS-1:0] K_MAX   = 5'd16;
    localparam logic [COUNT_BITS-1:0] K_MIN   = 5'd1;

    typedef struct packed {
        logic [IDX_BITS-1:0]  index;
        logic [DIST_BITS-1:0] dist_sq;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic trunc;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/k_nearest_insertion_selector_unit.sv =====
// top level: k-nearest selector with distance pipeline, insertion chain and result drain
`default_nettype none

// Brute-force k-nearest selector. A query word (operation 0) loads the query point
// and empties the list; each point word (operation 1) gets the next arrival index
// and its exact squared distance, then drops into a chain of 16 cells that keeps
// the k nearest in ascending order (a tie goes ahead of the stored entry); a
// finish word (operation 2) drains the list nearest first, or one word with
// found_count 0 when the list is empty. Query and point words are taken one per
// cycle while in_stall is low: an input register and three pipeline stages
// (difference, square, sum) feed the chain, and every cell of the chain compares
// against the new distance in parallel. A finish word holds off input (in_stall
// high) from the cycle after it reaches the chain until its last result word
// has been loaded into the output register. Points past the 65536th since the
// query are ignored, and operation 3 is ignored. neighbor_count must be written
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// 0 acts as 1 and values above 16 act as 16. Lowering k trims the list at the
// next point or finish word.

module k_nearest_insertion_selector_unit
    import knis_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [OP_BITS-1:0]           operation,
    input  wire logic signed [COORD_BITS-1:0] coord_x,
    input  wire logic signed [COORD_BITS-1:0] coord_y,
    input  wire logic signed [COORD_BITS-1:0] coord_z,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [RANK_BITS-1:0]              rank,
    output logic [IDX_BITS-1:0]               point_index,
    output logic [DIST_BITS-1:0]              distance_squared,
    output logic [COUNT_BITS-1:0]             found_count,
    output logic                              last_result,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [COUNT_BITS-1:0]        cfg_wr_data
);

    // neighbor count register and its clamped value
    logic [COUNT_BITS-1:0] nc_reg;
    logic [COUNT_BITS-1:0] k_eff;
    logic [MAX_K-1:0]      in_k_vec;

    // pipeline handoff
    logic                  advance;
    logic                  pipe_valid;
    logic [OP_BITS-1:0]    pipe_op;
    logic [DIST_BITS-1:0]  pipe_dist;
    logic                  apply;

    // list bookkeeping
    logic [COUNT_BITS-1:0] fill_reg;
    logic [COUNT_BITS-1:0] fill_next;
    logic [COUNT_BITS-1:0] fill_eff;
    logic [SEEN_BITS-1:0]  seen_reg;
    logic [SEEN_BITS-1:0]  seen_next;
    cell_cmd_t             chain_cmd;
    entry_t                new_entry;

    // chain wiring
    logic [MAX_K-1:0]      valid_vec;
    entry_t                entry_arr [MAX_K];
    logic [MAX_K:0]        ins_chain;

    // result drain
    logic                  emit_busy_reg;
    logic                  emit_busy_next;
    logic [COUNT_BITS-1:0] emit_cnt_reg;
    logic [COUNT_BITS-1:0] emit_cnt_next;
    logic [COUNT_BITS-1:0] emit_cnt_plus;
    logic [COUNT_BITS-1:0] emit_total_reg;
    logic [COUNT_BITS-1:0] emit_total_next;
    logic                  emit_last;
    logic                  emit_fire;
    logic                  out_free;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    entry_t                emit_entry;

    logic [RANK_BITS-1:0]  rank_reg;
    logic [IDX_BITS-1:0]   index_reg;
    logic [DIST_BITS-1:0]  dist_reg;
    logic [COUNT_BITS-1:0] found_reg;
    logic                  last_reg;

    // whole front end freezes while a finish drains the list
    assign advance  = !emit_busy_reg;
    assign in_stall = emit_busy_reg;

    always_comb
    begin
        if (nc_reg == '0)
        begin
            k_eff = K_MIN;
        end
        else if (nc_reg > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = nc_reg;
        end
    end

    // thermometer of slots inside k, one bit per cell
    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++)
        begin : g_in_k
            assign in_k_vec[gi] = (COUNT_BITS'(gi) < k_eff);
        end
    endgenerate

    knis_dist_pipe u_dist_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_op     (operation),
        .in_x      (coord_x),
        .in_y      (coord_y),
        .in_z      (coord_z),
        .out_valid (pipe_valid),
        .out_op    (pipe_op),
        .out_dist  (pipe_dist)
    );

    // list commands at the end of the pipeline
    always_comb
    begin
        apply            = advance && pipe_valid;
        fill_eff         = (fill_reg > k_eff) ? k_eff : fill_reg;
        chain_cmd.clear  = apply && (pipe_op == OP_QUERY);
        // the point counter's top bit marks the cap of 65536 points
        chain_cmd.insert = apply && (pipe_op == OP_POINT) && !seen_reg[SEEN_BITS-1];
        chain_cmd.trunc  = apply && (pipe_op == OP_FINISH);
        new_entry.index  = seen_reg[IDX_BITS-1:0];
        new_entry.dist_sq = pipe_dist;

        fill_next = fill_reg;
        seen_next = seen_reg;
        if (chain_cmd.clear)
        begin
            fill_next = '0;
            seen_next = '0;
        end
        else if (chain_cmd.insert)
        begin
            fill_next = (fill_eff < k_eff) ? (fill_eff + COUNT_BITS'(1)) : fill_eff;
            seen_next = seen_reg + SEEN_BITS'(1);
        end
        else if (chain_cmd.trunc)
        begin
            fill_next = fill_eff;
        end
    end

    // the insertion chain: the insert flag ripples right from the slot that takes the point
    assign ins_chain[0] = 1'b0;

    generate
        for (gi = 0; gi < MAX_K; gi++)
        begin : g_cell
            logic   left_valid;
            entry_t left_entry;

            if (gi == 0)
            begin : g_head
                assign left_valid = 1'b0;
                assign left_entry = '0;
            end
            else
            begin : g_body
                assign left_valid = valid_vec[gi-1];
                assign left_entry = entry_arr[gi-1];
            end

            knis_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (chain_cmd),
                .in_k       (in_k_vec[gi]),
                .new_entry  (new_entry),
                .left_valid (left_valid),
                .left_entry (left_entry),
                .ins_in     (ins_chain[gi]),
                .valid      (valid_vec[gi]),
                .entry      (entry_arr[gi]),
                .ins_out    (ins_chain[gi+1])
            );
        end
    endgenerate

    // drain: one list entry per free output slot
    always_comb
    begin
        out_free      = !out_valid_reg || !out_stall;
        emit_fire     = emit_busy_reg && out_free;
        emit_cnt_plus = emit_cnt_reg + COUNT_BITS'(1);
        // empty list gives a single word
        emit_last     = (emit_total_reg == '0) || (emit_cnt_plus == emit_total_reg);
        emit_entry    = (emit_total_reg == '0) ? '0 : entry_arr[emit_cnt_reg[RANK_BITS-1:0]];

        emit_busy_next  = emit_busy_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_total_next = emit_total_reg;
        if (chain_cmd.trunc)
        begin
            emit_busy_next  = 1'b1;
            emit_cnt_next   = '0;
            emit_total_next = fill_eff;
        end
        else if (emit_fire)
        begin
            if (emit_last)
            begin
                emit_busy_next = 1'b0;
            end
            else
            begin
                emit_cnt_next = emit_cnt_plus;
            end
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg         <= K_RESET;
            fill_reg       <= '0;
            seen_reg       <= '0;
            emit_busy_reg  <= 1'b0;
            emit_cnt_reg   <= '0;
            emit_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nc_reg <= cfg_wr_data;
            end
            fill_reg       <= fill_next;
            seen_reg       <= seen_next;
            emit_busy_reg  <= emit_busy_next;
            emit_cnt_reg   <= emit_cnt_next;
            emit_total_reg <= emit_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            rank_reg  <= emit_cnt_reg[RANK_BITS-1:0];
            index_reg <= emit_entry.index;
            dist_reg  <= emit_entry.dist_sq;
            found_reg <= emit_total_reg;
            last_reg  <= emit_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign rank             = rank_reg;
    assign point_index      = index_reg;
    assign distance_squared = dist_reg;
    assign found_count      = found_reg;
    assign last_result      = last_reg;

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + {{(MAX_K-1){1'b0}}, 1'b1})) == '0)
        else $error("chain occupancy is not a prefix");

    // fill counter tracks the occupied cells
    a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("fill count disagrees with chain");

    // a point always finds a slot while the list is short of k
    a_insert_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_cmd.insert && (fill_eff < k_eff)) |-> ins_chain[MAX_K])
        else $error("point lost while list not full");

    // drain counter stays inside the list
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_busy_reg |-> ((emit_cnt_reg < emit_total_reg) ||
                           ((emit_total_reg == '0) && (emit_cnt_reg == '0))))
        else $error("drain counter past list end");

    // the word after a last word never continues the same list
    a_rank_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_result) |=> (!out_valid || (rank == '0)))
        else $error("result after last word did not restart at rank 0");

endmodule

`default_nettype wire

// ===== rtl/knis_dist_pipe.sv =====
// query register and squared distance pipeline
`default_nettype none

module knis_dist_pipe
    import knis_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         in_valid,
    input  wire logic [OP_BITS-1:0]           in_op,
    input  wire logic signed [COORD_BITS-1:0] in_x,
    input  wire logic signed [COORD_BITS-1:0] in_y,
    input  wire logic signed [COORD_BITS-1:0] in_z,
    output logic                              out_valid,
    output logic [OP_BITS-1:0]                out_op,
    output logic [DIST_BITS-1:0]              out_dist
);

    // input stage
    logic                  s0_valid_reg;
    logic [OP_BITS-1:0]    s0_op_reg;
    logic [COORD_BITS-1:0] s0_x_reg;
    logic [COORD_BITS-1:0] s0_y_reg;
    logic [COORD_BITS-1:0] s0_z_reg;

    logic [COORD_BITS-1:0] qx_reg;
    logic [COORD_BITS-1:0] qy_reg;
    logic [COORD_BITS-1:0] qz_reg;

    // absolute differences
    logic                  s1_valid_reg;
    logic [OP_BITS-1:0]    s1_op_reg;
    logic [COORD_BITS-1:0] s1_dx_reg;
    logic [COORD_BITS-1:0] s1_dy_reg;
    logic [COORD_BITS-1:0] s1_dz_reg;

    // squares
    logic                  s2_valid_reg;
    logic [OP_BITS-1:0]    s2_op_reg;
    logic [SQ_BITS-1:0]    s2_sx_reg;
    logic [SQ_BITS-1:0]    s2_sy_reg;
    logic [SQ_BITS-1:0]    s2_sz_reg;

    // sum
    logic                  s3_valid_reg;
    logic [OP_BITS-1:0]    s3_op_reg;
    logic [DIST_BITS-1:0]  s3_dist_reg;

    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_next;
    logic [COORD_BITS-1:0] dz_next;
    logic [DIST_BITS-1:0]  dist_next;
    logic                  load_query;

    // magnitude of a - b always fits in the coordinate width unsigned
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        begin
            d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
            m = d[COORD_BITS] ? (~d + {{COORD_BITS{1'b0}}, 1'b1}) : d;
            abs_diff = m[COORD_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        dx_next    = abs_diff(s0_x_reg, qx_reg);
        dy_next    = abs_diff(s0_y_reg, qy_reg);
        dz_next    = abs_diff(s0_z_reg, qz_reg);
        dist_next  = DIST_BITS'(s2_sx_reg) + DIST_BITS'(s2_sy_reg) + DIST_BITS'(s2_sz_reg);
        load_query = advance && s0_valid_reg && (s0_op_reg == OP_QUERY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            qx_reg       <= '0;
            qy_reg       <= '0;
            qz_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                s0_valid_reg <= in_valid;
                s1_valid_reg <= s0_valid_reg;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            if (load_query)
            begin
                qx_reg <= s0_x_reg;
                qy_reg <= s0_y_reg;
                qz_reg <= s0_z_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_op_reg   <= in_op;
            s0_x_reg    <= in_x;
            s0_y_reg    <= in_y;
            s0_z_reg    <= in_z;
            s1_op_reg   <= s0_op_reg;
            s1_dx_reg   <= dx_next;
            s1_dy_reg   <= dy_next;
            s1_dz_reg   <= dz_next;
            s2_op_reg   <= s1_op_reg;
            s2_sx_reg   <= s1_dx_reg * s1_dx_reg;
            s2_sy_reg   <= s1_dy_reg * s1_dy_reg;
            s2_sz_reg   <= s1_dz_reg * s1_dz_reg;
            s3_op_reg   <= s2_op_reg;
            s3_dist_reg <= dist_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_op    = s3_op_reg;
    assign out_dist  = s3_dist_reg;

endmodule

`default_nettype wire

// ===== rtl/knis_cell.sv =====
// one slot of the sorted insertion chain
`default_nettype none

module knis_cell
    import knis_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire logic      in_k,
    input  wire entry_t    new_entry,
    input  wire logic      left_valid,
    input  wire entry_t    left_entry,
    input  wire logic      ins_in,
    output logic           valid,
    output entry_t         entry,
    output logic           ins_out
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   occ;
    logic   take;

    always_comb
    begin
        // slots past k drop out of the list at the next point or finish
        occ     = valid_reg && in_k;
        // equal distance goes ahead of the stored one
        take    = cmd.insert && (!occ || (new_entry.dist_sq <= entry_reg.dist_sq));
        ins_out = ins_in || take;

        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.insert)
        begin
            if (ins_in)
            begin
                valid_next = left_valid && in_k;
                entry_next = left_entry;
            end
            else if (take)
            begin
                valid_next = in_k;
                entry_next = new_entry;
            end
            else
            begin
                valid_next = occ;
            end
        end
        else if (cmd.trunc)
        begin
            valid_next = occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== bench/k_nearest_insertion_selector_unit_test.sv =====
// self-checking testbench for the k-nearest insertion selector unit
`timescale 1ns / 100ps

module k_nearest_insertion_selector_unit_test
    import knis_pkg::*;
();

    // operation code the block must ignore
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    // points accepted per query before further points are ignored
    localparam int POINT_LIMIT = 65536;

    // cycles to let a point clear the distance pipeline once results are in
    localparam int SETTLE_CYCLES = 12;

    // cycles with no accepted word on either channel before giving up
    localparam int QUIET_LIMIT = 4000;

    // mismatch lines printed before going quiet (all are still counted)
    localparam int PRINT_CAP = 40;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // one input word waiting to be sent
    typedef struct {
        logic [OP_BITS-1:0]           op;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } word_t;

    // one neighbor result word as the block should emit it
    typedef struct packed {
        logic [RANK_BITS-1:0]  rank;
        logic [IDX_BITS-1:0]   index;
        logic [DIST_BITS-1:0]  dist_sq;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } neighbor_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [OP_BITS-1:0]           operation = OP_QUERY;
    logic signed [COORD_BITS-1:0] coord_x   = '0;
    logic signed [COORD_BITS-1:0] coord_y   = '0;
    logic signed [COORD_BITS-1:0] coord_z   = '0;

    // result channel
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [RANK_BITS-1:0]  rank;
    logic [IDX_BITS-1:0]   point_index;
    logic [DIST_BITS-1:0]  distance_squared;
    logic [COUNT_BITS-1:0] found_count;
    logic                  last_result;

    // configuration
    logic                  cfg_wr_en   = 1'b0;
    logic [COUNT_BITS-1:0] cfg_wr_data = '0;

    // words still to be sent, and the neighbor words the block still owes
    word_t     word_backlog[$];
    neighbor_t nearest_due[$];
    word_t     next_word;

    // our own copy of the selector state
    logic signed [COORD_BITS-1:0] query_x = '0;
    logic signed [COORD_BITS-1:0] query_y = '0;
    logic signed [COORD_BITS-1:0] query_z = '0;
    entry_t                       kept[MAX_K];
    int                           kept_fill   = 0;
    int                           seen_points = 0;
    logic [COUNT_BITS-1:0]        neighbor_k  = K_RESET;

    // center that generated points cluster around, so ties are common
    logic signed [COORD_BITS-1:0] cen_x = '0;
    logic signed [COORD_BITS-1:0] cen_y = '0;
    logic signed [COORD_BITS-1:0] cen_z = '0;

    // bookkeeping
    int words_queued    = 0;
    int words_accepted  = 0;
    int items_made      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;

    k_nearest_insertion_selector_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .rank             (rank),
        .point_index      (point_index),
        .distance_squared (distance_squared),
        .found_count      (found_count),
        .last_result      (last_result),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // exact squared difference of one axis, widened so nothing wraps
    function automatic logic [DIST_BITS-1:0] square_gap(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] gap;
        logic [COORD_BITS:0]        mag;
        gap = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
        mag = gap[COORD_BITS] ? -gap : gap;
        return DIST_BITS'(mag) * DIST_BITS'(mag);
    endfunction

    // update the kept list for one accepted word and queue the neighbor words it owes
    task automatic track_nearest(
        input logic [OP_BITS-1:0]           op,
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [COORD_BITS-1:0] z
    );
        logic [DIST_BITS-1:0] d;
        neighbor_t            hit;
        int                   k;
        int                   pos;
        int                   i;
        // zero acts as one, anything past the list depth acts as full depth
        k = (neighbor_k == 0) ? 1 : ((neighbor_k > MAX_K) ? MAX_K : int'(neighbor_k));
        case (op)
            OP_QUERY:
            begin
                query_x     = x;
                query_y     = y;
                query_z     = z;
                kept_fill   = 0;
                seen_points = 0;
            end
            OP_POINT:
            begin
                if (seen_points < POINT_LIMIT)
                begin
                    // a lowered k trims the list before the point goes in
                    if (kept_fill > k)
                        kept_fill = k;
                    d = square_gap(x, query_x) + square_gap(y, query_y)
                      + square_gap(z, query_z);
                    // first slot whose distance is not below the new one: ties go ahead
                    pos = kept_fill;
                    for (i = kept_fill - 1; i >= 0; i--)
                        if (d <= kept[i].dist_sq)
                            pos = i;
                    // a full list drops its farthest entry, or the point itself
                    if (pos < k)
                    begin
                        if (kept_fill < k)
                            kept_fill++;
                        for (i = kept_fill - 1; i > pos; i--)
                            kept[i] = kept[i-1];
                        kept[pos].index   = IDX_BITS'(seen_points);
                        kept[pos].dist_sq = d;
                    end
                    seen_points++;
                end
            end
            OP_FINISH:
            begin
                if (kept_fill > k)
                    kept_fill = k;
                if (kept_fill == 0)
                begin
                    // empty list still answers with a single closing word
                    hit      = '0;
                    hit.last = 1'b1;
                    nearest_due.push_back(hit);
                end
                else
                begin
                    for (i = 0; i < kept_fill; i++)
                    begin
                        hit.rank    = RANK_BITS'(i);
                        hit.index   = kept[i].index;
                        hit.dist_sq = kept[i].dist_sq;
                        hit.count   = COUNT_BITS'(kept_fill);
                        hit.last    = (i == kept_fill - 1);
                        nearest_due.push_back(hit);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic flag_mismatch(
        input string           what,
        input longint unsigned seen,
        input longint unsigned wanted
    );
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, seen, wanted);
    endtask

    // driver: presents backlog words, holds a word while stalled, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= OP_QUERY;
            coord_x   <= '0;
            coord_y   <= '0;
            coord_z   <= '0;
        end
        else
        begin
            // word taken at this edge: predict from the values it carried
            if (in_valid && !in_stall)
            begin
                track_nearest(operation, coord_x, coord_y, coord_z);
                words_accepted++;
            end
            // free to move on only when nothing is held
            if (!in_valid || !in_stall)
            begin
                if (word_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = word_backlog.pop_front();
                    in_valid  <= 1'b1;
                    operation <= next_word.op;
                    coord_x   <= next_word.x;
                    coord_y   <= next_word.y;
                    coord_z   <= next_word.z;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each taken result word against the oldest one owed
    always @(posedge clk or negedge rst_n)
    begin
        neighbor_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (nearest_due.size() == 0)
                begin
                    flag_mismatch("result word with none owed (point_index)", point_index, 0);
                end
                else
                begin
                    want = nearest_due.pop_front();
                    if (rank !== want.rank)
                        flag_mismatch("rank", rank, want.rank);
                    if (point_index !== want.index)
                        flag_mismatch("point_index", point_index, want.index);
                    if (distance_squared !== want.dist_sq)
                        flag_mismatch("distance_squared", distance_squared, want.dist_sq);
                    if (found_count !== want.count)
                        flag_mismatch("found_count", found_count, want.count);
                    if (last_result !== want.last)
                        flag_mismatch("last_result", last_result, want.last);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // count cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t ns  no progress for %0d cycles, %0d results still owed",
                 $time, QUIET_LIMIT, nearest_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic queue_word(
        input logic [OP_BITS-1:0]           op,
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [COORD_BITS-1:0] z
    );
        word_t w;
        w.op = op;
        w.x  = x;
        w.y  = y;
        w.z  = z;
        word_backlog.push_back(w);
        words_queued++;
        // ignored words do not count toward the stimulus size
        if (op != OP_UNUSED)
            items_made++;
    endtask

    // mostly full-range values, with the extremes showing up often
    function automatic logic signed [COORD_BITS-1:0] any_coord();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
        return COORD_BITS'($urandom);
    endfunction

    // close to the center half of the time, which makes equal distances likely
    function automatic logic signed [COORD_BITS-1:0] near_coord(
        input logic signed [COORD_BITS-1:0] c
    );
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
        if (pick <= 4)
            return c + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
        return COORD_BITS'($urandom);
    endfunction

    task automatic queue_query();
        cen_x = any_coord();
        cen_y = any_coord();
        cen_z = any_coord();
        queue_word(OP_QUERY, cen_x, cen_y, cen_z);
    endtask

    task automatic queue_points(input int n);
        int i;
        for (i = 0; i < n; i++)
            queue_word(OP_POINT, near_coord(cen_x), near_coord(cen_y), near_coord(cen_z));
    endtask

    task automatic queue_finish();
        queue_word(OP_FINISH, any_coord(), any_coord(), any_coord());
    endtask

    // random traffic: mostly query / points / finish runs, with noise mixed in
    task automatic queue_random_words(input int target);
        int start;
        int n;
        start = items_made;
        while (items_made - start < target)
        begin
            case ($urandom_range(0, 9))
                7: queue_word(OP_UNUSED, any_coord(), any_coord(), any_coord());
                8: queue_finish();
                9:
                begin
                    // keep adding to whatever list is already there
                    queue_points($urandom_range(1, 6));
                    queue_finish();
                end
                default:
                begin
                    queue_query();
                    n = $urandom_range(0, 20);
                    queue_points(n);
                    queue_finish();
                    if ($urandom_range(0, 3) == 0)
                        queue_finish();
                    if ($urandom_range(0, 3) == 0)
                    begin
                        queue_points($urandom_range(1, 8));
                        queue_finish();
                    end
                end
            endcase
        end
    endtask

    // sender holds off until every owed word is back and the pipeline is empty
    task automatic settle();
        while (words_accepted != words_queued || nearest_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called once settled, so the local copy of k can follow at once
    task automatic write_neighbor_count(input logic [COUNT_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        neighbor_k  = value;
    endtask

    // stimulus sequence
    initial
    begin
        int phase;
        int k_value;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // slow sender, busy receiver for the directed words and the first phases
        send_idle_pct = 17;
        recv_idle_pct = 64;

        // directed, k at its reset value: empty finish, ignored code, extremes, ties
        queue_finish();
        queue_word(OP_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX);
        queue_word(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_word(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_word(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_word(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_word(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_finish();
        // list survives a finish: emit again, then keep adding
        queue_finish();
        queue_word(OP_POINT, COORD_MIN + COORD_BITS'(1), COORD_MIN, COORD_MIN);
        queue_finish();
        // new query empties the list
        queue_word(OP_QUERY, COORD_MAX, COORD_MIN, '0);
        queue_finish();
        queue_word(OP_POINT, COORD_MIN, COORD_MAX, '1);
        queue_finish();
        settle();

        // directed, k of two: farther point dropped, ties replace the tail
        write_neighbor_count(5'd2);
        queue_word(OP_QUERY, '0, '0, '0);
        queue_word(OP_POINT, 16'sd1, '0, '0);
        queue_word(OP_POINT, 16'sd2, '0, '0);
        queue_word(OP_POINT, 16'sd3, '0, '0);
        queue_word(OP_POINT, '0, 16'sd2, '0);
        queue_word(OP_POINT, '0, '0, -16'sd1);
        queue_finish();
        settle();

        // random phases through a range of k settings, including out-of-range ones
        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: k_value = 16;
                1: k_value = 3;
                2: k_value = 0;
                3: k_value = 31;
                4: k_value = 1;
                5: k_value = 9;
                6: k_value = 17;
                7: k_value = 5;
                default: k_value = 16;
            endcase
            if (phase < 3)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 64;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_neighbor_count(COUNT_BITS'(k_value));
            // opening finish shows the previous list cut to the new k
            queue_finish();
            queue_random_words(10);
            // leave a well-filled list behind for the next setting to trim
            queue_query();
            queue_points(21);
            settle();
        end

        $display("checked %0d result words from %0d input words", results_checked,
                 words_accepted);
        $display("k from 0 to 31 incl. trims, ties, empty lists and repeated finishes");
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
